// ===== rtl/qfa_pkg.sv =====
`timescale 1ns / 1ps
package qfa_pkg;

  // Operand and result width, Q16.16
  localparam int DW     = 32;
  // Binary point position
  localparam int FRAC   = 16;
  // Dividend pre-shift for the rounded divide
  localparam int DIVSH  = 17;
  // Shifted dividend width, also the number of quotient bits
  localparam int QW     = DW + DIVSH;
  // One divider stage per quotient bit
  localparam int NDIV   = QW;
  // Width of the product bits that reach the result
  localparam int PW     = DW + FRAC;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t            kind;
    logic           is_signed;
    logic [DW-1:0]  operand_a;
    logic [DW-1:0]  operand_b;
  } in_word_t;

  typedef struct packed {
    logic [DW-1:0]  result_bits;
    logic           divide_by_zero;
  } out_word_t;

  // Payload carried down the pipeline
  typedef struct packed {
    op_t            kind;
    logic           neg;   // result sign must be flipped
    logic           dz;    // divide with zero divisor
    logic [DW-1:0]  res;   // add/sub/mul result
    logic [DW-1:0]  dvs;   // divisor magnitude
    logic [DW-1:0]  rem;   // partial remainder
    logic [QW-1:0]  dq;    // dividend shifting out, quotient shifting in
  } stage_t;

endpackage

// ===== rtl/qfa_front.sv =====
`timescale 1ns / 1ps
module qfa_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  qfa_pkg::in_word_t in_word,
  output logic             out_vld,
  output qfa_pkg::stage_t  out_stage
);
  import qfa_pkg::*;

  logic             v1_r, v2_r, v3_r;
  stage_t           s1_r, s2_r, s3_r;
  stage_t           s1_nxt, s3_nxt;
  logic [2*DW-1:0]  prod_r;
  logic [DW-1:0]    a_mag, b_mag;
  logic [PW-1:0]    pn, rnd;

  // Stage 1: magnitudes, add/sub, zero divisor check
  always_comb begin
    a_mag = (in_word.is_signed && in_word.operand_a[DW-1]) ? (~in_word.operand_a + 1'b1)
                                                             : in_word.operand_a;
    b_mag = (in_word.is_signed && in_word.operand_b[DW-1]) ? (~in_word.operand_b + 1'b1)
                                                             : in_word.operand_b;
    s1_nxt      = '0;
    s1_nxt.kind = in_word.kind;
    s1_nxt.neg  = in_word.is_signed && (in_word.operand_a[DW-1] ^ in_word.operand_b[DW-1]);
    s1_nxt.dz   = (in_word.kind == OP_DIV) && (in_word.operand_b == '0);
    s1_nxt.res  = (in_word.kind == OP_SUB) ? (in_word.operand_a - in_word.operand_b)
                                           : (in_word.operand_a + in_word.operand_b);
    s1_nxt.dvs  = b_mag;
    s1_nxt.rem  = '0;
    s1_nxt.dq   = {a_mag, {DIVSH{1'b0}}};
  end

  // Stage 3: sign fix and rounding of the product
  always_comb begin
    pn     = s2_r.neg ? (~prod_r[PW-1:0] + 1'b1) : prod_r[PW-1:0];
    rnd    = pn + (PW'(1) << (FRAC - 1));
    s3_nxt = s2_r;
    if (s2_r.kind == OP_MUL) begin
      s3_nxt.res = rnd[PW-1:FRAC];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload; stage 2 forms the magnitude product
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= s1_nxt;
      s2_r   <= s1_r;
      prod_r <= (2*DW)'(s1_r.dq[QW-1:DIVSH]) * (2*DW)'(s1_r.dvs);
      s3_r   <= s3_nxt;
    end
  end

  assign out_vld   = v3_r;
  assign out_stage = s3_r;

endmodule

// ===== rtl/qfa_div_step.sv =====
`timescale 1ns / 1ps
module qfa_div_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  qfa_pkg::stage_t in_stage,
  output logic            out_vld,
  output qfa_pkg::stage_t out_stage
);
  import qfa_pkg::*;

  logic          vld_r;
  stage_t        stg_r, stg_nxt;
  logic [DW:0]   sh, diff;
  logic          ge;

  // One restoring division bit
  always_comb begin
    sh      = {in_stage.rem, in_stage.dq[QW-1]};
    ge      = sh >= {1'b0, in_stage.dvs};
    diff    = sh - {1'b0, in_stage.dvs};
    stg_nxt = in_stage;
    stg_nxt.rem = ge ? diff[DW-1:0] : sh[DW-1:0];
    stg_nxt.dq  = {in_stage.dq[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_vld   = vld_r;
  assign out_stage = stg_r;

endmodule

// ===== rtl/qfa_finish.sv =====
`timescale 1ns / 1ps
module qfa_finish (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  qfa_pkg::stage_t    in_stage,
  output logic               out_vld,
  output qfa_pkg::out_word_t out_word
);
  import qfa_pkg::*;

  logic          vld_r;
  out_word_t     word_r, word_nxt;
  logic [DW+1:0] qn, qr;

  // Quotient sign fix and round-half; only the low bits reach the result
  always_comb begin
    qn = in_stage.neg ? (~in_stage.dq[DW+1:0] + 1'b1) : in_stage.dq[DW+1:0];
    qr = qn + 1'b1;
    word_nxt = '0;
    if (in_stage.kind == OP_DIV) begin
      word_nxt.divide_by_zero = in_stage.dz;
      word_nxt.result_bits    = in_stage.dz ? '0 : qr[DW:1];
    end else begin
      word_nxt.result_bits    = in_stage.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

// ===== rtl/q16_16_fixed_point_alu_core.sv =====
`timescale 1ns / 1ps
// Q16.16 arithmetic unit: add, subtract, rounded multiply, rounded divide.
// Input channel: in_valid / in_stall / in_word (kind, is_signed, operands).
// Result channel: out_valid / out_stall / out_word (result, divide_by_zero).
// A word is taken on a rising edge with valid high and stall low.
// Every operation runs through the same pipeline, so results leave in the
// order the words came in. From acceptance to out_valid a word passes
// through three front stages (magnitudes, 32x32 multiply, rounding), 49 divider
// stages that each settle one quotient bit, and the output register.
// Throughput is one word per cycle, any op mix, while no output is stalled.
// When the receiver stalls a valid output word, the whole pipeline freezes
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Bubbles in the input stream travel down the pipeline as empty slots.
// Reset (rst_n low, synchronous) clears all valid bits; the pipeline is
// empty and ready on the first cycle after reset.
module q16_16_fixed_point_alu_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  qfa_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output qfa_pkg::out_word_t out_word
);
  import qfa_pkg::*;

  logic   adv;
  logic   vld   [0:NDIV];
  stage_t stg   [0:NDIV];

  // Global advance: hold everything while the output word is stalled
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  qfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (in_valid),
    .in_word   (in_word),
    .out_vld   (vld[0]),
    .out_stage (stg[0])
  );

  // Divider chain
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    qfa_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_vld    (vld[i]),
      .in_stage  (stg[i]),
      .out_vld   (vld[i+1]),
      .out_stage (stg[i+1])
    );
  end

  qfa_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (vld[NDIV]),
    .in_stage (stg[NDIV]),
    .out_vld  (out_valid),
    .out_word (out_word)
  );

  // Zero divisor always comes with a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.divide_by_zero |-> out_word.result_bits == '0)
    else $error("divide_by_zero with non-zero result");

  // A stall freezes the pipeline
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld[0]) && $stable(vld[NDIV]))
    else $error("pipeline moved while stalled");

  // Input is held off only because of a waiting output word
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule
